// ----- hdl/rghs_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rghs_pkg: shared types and constants of the rate-gated height smoother
// Payload structs, configuration struct, controller command/status structs,
// verdict codes, register indexes and fixed-point constants.
// ----------------------------------------------------------------------------
package rghs_pkg;

  // Widths of the reading and of heights in sixteenths of a mm
  localparam int RAW_W  = 16;
  localparam int FRAC_W = 4;
  localparam int H_W    = RAW_W + FRAC_W;

  // Moving-average window
  localparam int WINDOW_LEN = 5;
  localparam int SLOT_W     = $clog2(WINDOW_LEN);
  localparam int TOTAL_W    = H_W + $clog2(WINDOW_LEN);

  // Mean by reciprocal: q = (n * RECIP) >> TOTAL_W, low by at most one
  localparam logic [TOTAL_W-1:0] RECIP    = TOTAL_W'((64'd1 << TOTAL_W) / WINDOW_LEN);
  localparam logic [TOTAL_W-1:0] WIN_N    = TOTAL_W'(WINDOW_LEN);
  localparam logic [TOTAL_W-1:0] WIN_HALF = TOTAL_W'(WINDOW_LEN / 2);

  // Blend in 1/65536 units
  localparam int W_W        = 16;
  localparam int PROD_W     = H_W + W_W;
  localparam int BLEND_FRAC = W_W;
  localparam logic [PROD_W:0] BLEND_ROUND = (PROD_W + 1)'(1) << (BLEND_FRAC - 1);

  // Verdict codes
  localparam logic [2:0] VERDICT_OK      = 3'd0;
  localparam logic [2:0] VERDICT_RANGE   = 3'd1;
  localparam logic [2:0] VERDICT_DROP    = 3'd2;
  localparam logic [2:0] VERDICT_RISE    = 3'd3;
  localparam logic [2:0] VERDICT_RUNAWAY = 3'd4;

  // Configuration register map
  localparam int ADDR_W = 5;
  localparam logic [2:0] REG_MAX_HEIGHT   = 3'd0;
  localparam logic [2:0] REG_MAX_DROP     = 3'd1;
  localparam logic [2:0] REG_MAX_RISE     = 3'd2;
  localparam logic [2:0] REG_RUNAWAY_RISE = 3'd3;
  localparam logic [2:0] REG_RUNAWAY_OUT  = 3'd4;
  localparam logic [2:0] REG_BLEND_ONSET  = 3'd5;
  localparam logic [2:0] REG_BLEND_STEP   = 3'd6;
  localparam logic [2:0] REG_BLEND_WEIGHT = 3'd7;

  typedef struct packed {
    logic [7:0] height_high;
    logic [7:0] height_low;
  } in_t;

  typedef struct packed {
    logic [H_W-1:0]   filtered_height;
    logic [RAW_W-1:0] raw_height_mm;
    logic [2:0]       verdict;
  } out_t;

  typedef struct packed {
    logic [15:0] max_height_mm;
    logic [15:0] max_drop_mm;
    logic [15:0] max_rise_mm;
    logic [15:0] runaway_rise_mm;
    logic [15:0] runaway_output_mm;
    logic [15:0] blend_onset_mm;
    logic [15:0] blend_step_mm;
    logic [15:0] blend_weight;
  } cfg_t;

  // Controller to datapath
  typedef struct packed {
    logic latch;     // take the input transaction
    logic check;     // register blend decision and blend product
    logic blend;     // form the sample value, update last accepted
    logic update;    // write the window and the running total
    logic mul;       // reciprocal multiply of the rounded total
    logic finish;    // store the mean and load the result register
    logic load_rej;  // load a rejected result
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic reject;
  } sts_t;

endpackage
`default_nettype wire

// ----- hdl/rghs_regs.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rghs_regs: configuration register file
// Eight 16-bit registers on an APB-style port, one per word address.
// ----------------------------------------------------------------------------
module rghs_regs import rghs_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  cfg_t       cfg_q;
  logic [2:0] idx;
  logic [15:0] rd_val;

  assign idx    = paddr[ADDR_W-1:2];
  assign pready = 1'b1;

  // Write on the access phase
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_height_mm     <= 16'd2500;
      cfg_q.max_drop_mm       <= 16'd400;
      cfg_q.max_rise_mm       <= 16'd400;
      cfg_q.runaway_rise_mm   <= 16'd600;
      cfg_q.runaway_output_mm <= 16'd3000;
      cfg_q.blend_onset_mm    <= 16'd600;
      cfg_q.blend_step_mm     <= 16'd40;
      cfg_q.blend_weight      <= 16'd3277;
    end else if (psel && penable && pwrite) begin
      case (idx)
        REG_MAX_HEIGHT:   cfg_q.max_height_mm     <= pwdata[15:0];
        REG_MAX_DROP:     cfg_q.max_drop_mm       <= pwdata[15:0];
        REG_MAX_RISE:     cfg_q.max_rise_mm       <= pwdata[15:0];
        REG_RUNAWAY_RISE: cfg_q.runaway_rise_mm   <= pwdata[15:0];
        REG_RUNAWAY_OUT:  cfg_q.runaway_output_mm <= pwdata[15:0];
        REG_BLEND_ONSET:  cfg_q.blend_onset_mm    <= pwdata[15:0];
        REG_BLEND_STEP:   cfg_q.blend_step_mm     <= pwdata[15:0];
        REG_BLEND_WEIGHT: cfg_q.blend_weight      <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    case (idx)
      REG_MAX_HEIGHT:   rd_val = cfg_q.max_height_mm;
      REG_MAX_DROP:     rd_val = cfg_q.max_drop_mm;
      REG_MAX_RISE:     rd_val = cfg_q.max_rise_mm;
      REG_RUNAWAY_RISE: rd_val = cfg_q.runaway_rise_mm;
      REG_RUNAWAY_OUT:  rd_val = cfg_q.runaway_output_mm;
      REG_BLEND_ONSET:  rd_val = cfg_q.blend_onset_mm;
      REG_BLEND_STEP:   rd_val = cfg_q.blend_step_mm;
      REG_BLEND_WEIGHT: rd_val = cfg_q.blend_weight;
      default:          rd_val = 16'd0;
    endcase
  end

  assign prdata = {16'd0, rd_val};
  assign cfg_o  = cfg_q;

endmodule
`default_nettype wire

// ----- hdl/rghs_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rghs_ctrl: sequencing controller
// Steps one transaction through check, blend, window update, multiply and
// correction, and owns the input stall and the result valid flag.
// ----------------------------------------------------------------------------
module rghs_ctrl import rghs_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  output logic out_valid_o,
  input  logic out_stall_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_CHECK  = 6'b000010,
    S_BLEND  = 6'b000100,
    S_UPDATE = 6'b001000,
    S_MUL    = 6'b010000,
    S_CORR   = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;
  logic   load;

  // Result register can take a new value
  assign out_free = !out_valid_q || !out_stall_i;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_CHECK;
      end
      S_CHECK: begin
        if (!sts_i.reject) state_d = S_BLEND;
        else if (out_free) state_d = S_IDLE;
      end
      S_BLEND:  state_d = S_UPDATE;
      S_UPDATE: state_d = S_MUL;
      S_MUL:    state_d = S_CORR;
      S_CORR: begin
        if (out_free) state_d = S_IDLE;
      end
      default:  state_d = S_IDLE;
    endcase
  end

  // Datapath commands
  always_comb begin
    cmd_o.latch    = (state_q == S_IDLE) && in_valid_i;
    cmd_o.check    = (state_q == S_CHECK);
    cmd_o.blend    = (state_q == S_BLEND);
    cmd_o.update   = (state_q == S_UPDATE);
    cmd_o.mul      = (state_q == S_MUL);
    cmd_o.finish   = (state_q == S_CORR) && out_free;
    cmd_o.load_rej = (state_q == S_CHECK) && sts_i.reject && out_free;
  end

  assign load = cmd_o.finish || cmd_o.load_rej;

  // Hold valid until the receiver takes the result
  always_comb begin
    out_valid_d = out_valid_q;
    if (load) out_valid_d = 1'b1;
    else if (!out_stall_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

`ifndef SYNTHESIS
  a_accept_to_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> state_q == S_CHECK)
    else $error("accepted transaction did not enter check");

  a_reject_no_blend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CHECK && sts_i.reject |=> state_q != S_BLEND)
    else $error("rejected reading went on to blend");

  a_rise_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == S_CHECK || $past(state_q) == S_CORR))
    else $error("result valid rose outside check or correction");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stall_i && !load |=> out_valid_q)
    else $error("stalled result dropped");
`endif

endmodule
`default_nettype wire

// ----- hdl/rghs_dp.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rghs_dp: filter datapath
// Outlier tests, blend multiply, five-sample ring with running total,
// reciprocal-multiply mean and the result register.
// ----------------------------------------------------------------------------
module rghs_dp import rghs_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  cfg_t cfg_i,
  input  in_t  in_data_i,
  input  cmd_t cmd_i,
  output sts_t sts_o,
  output out_t out_data_o
);

  // Filter state
  logic [H_W-1:0]     lf_q;
  logic [H_W-1:0]     la_q;
  logic [TOTAL_W-1:0] total_q;
  logic [SLOT_W-1:0]  slot_q;
  logic [H_W-1:0]     samples_q [WINDOW_LEN];

  // Per-transaction working registers
  logic [RAW_W-1:0]     raw_q;
  logic                 do_blend_q;
  logic [PROD_W-1:0]    prod_q;
  logic [H_W-1:0]       hv_q;
  logic [2*TOTAL_W-1:0] mprod_q;
  out_t                 out_q;

  logic [H_W-1:0]     h_c, up_c, dn_c, step_c, rej_val_c, hv_c, mean_c;
  logic [2:0]         verdict_c;
  logic               blend_c;
  logic [PROD_W:0]    blend_sum_c;
  logic [TOTAL_W-1:0] total_d, n_c, q_c, rem_c, q_fix_c;

  assign h_c    = {raw_q, {FRAC_W{1'b0}}};
  assign up_c   = h_c - lf_q;
  assign dn_c   = lf_q - h_c;
  assign step_c = h_c - la_q;

  // Outlier tests in priority order
  always_comb begin
    verdict_c = VERDICT_OK;
    rej_val_c = lf_q;
    if (raw_q > cfg_i.max_height_mm) begin
      verdict_c = VERDICT_RANGE;
    end else if (h_c < lf_q && dn_c > {cfg_i.max_drop_mm, {FRAC_W{1'b0}}}) begin
      verdict_c = VERDICT_DROP;
    end else if (h_c > lf_q && up_c > {cfg_i.max_rise_mm, {FRAC_W{1'b0}}}) begin
      if (up_c > {cfg_i.runaway_rise_mm, {FRAC_W{1'b0}}}) begin
        verdict_c = VERDICT_RUNAWAY;
        rej_val_c = {cfg_i.runaway_output_mm, {FRAC_W{1'b0}}};
      end else begin
        verdict_c = VERDICT_RISE;
      end
    end
  end

  // Blend only a sharp step up above the onset height
  assign blend_c = (h_c > {cfg_i.blend_onset_mm, {FRAC_W{1'b0}}}) && (h_c > la_q) &&
                   (step_c > {cfg_i.blend_step_mm, {FRAC_W{1'b0}}});

  assign sts_o.reject = (verdict_c != VERDICT_OK);

  // prev + (h - prev) * w / 65536, rounded half up
  assign blend_sum_c = {1'b0, la_q, {BLEND_FRAC{1'b0}}} + {1'b0, prod_q} + BLEND_ROUND;
  assign hv_c = do_blend_q ? blend_sum_c[PROD_W-1:BLEND_FRAC] : h_c;

  // Replace the oldest sample in the running total
  assign total_d = total_q - TOTAL_W'(samples_q[slot_q]) + TOTAL_W'(hv_q);

  // Mean correction: estimate is low by at most one
  assign n_c     = total_q + WIN_HALF;
  assign q_c     = mprod_q[2*TOTAL_W-1:TOTAL_W];
  assign rem_c   = n_c - q_c * WIN_N;
  assign q_fix_c = (rem_c >= WIN_N) ? q_c + TOTAL_W'(1) : q_c;
  assign mean_c  = q_fix_c[H_W-1:0];

  // Working registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) raw_q <= {in_data_i.height_high, in_data_i.height_low};
    if (cmd_i.check) begin
      do_blend_q <= blend_c;
      prod_q     <= step_c * cfg_i.blend_weight;
    end
    if (cmd_i.blend) hv_q <= hv_c;
    if (cmd_i.mul)   mprod_q <= n_c * RECIP;
    if (cmd_i.load_rej) begin
      out_q.filtered_height <= rej_val_c;
      out_q.raw_height_mm   <= raw_q;
      out_q.verdict         <= verdict_c;
    end else if (cmd_i.finish) begin
      out_q.filtered_height <= mean_c;
      out_q.raw_height_mm   <= raw_q;
      out_q.verdict         <= VERDICT_OK;
    end
  end

  // Filter state, cleared at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lf_q    <= '0;
      la_q    <= '0;
      total_q <= '0;
      slot_q  <= '0;
      for (int i = 0; i < WINDOW_LEN; i++) begin
        samples_q[i] <= '0;
      end
    end else begin
      if (cmd_i.blend) la_q <= hv_c;
      if (cmd_i.update) begin
        total_q           <= total_d;
        samples_q[slot_q] <= hv_q;
        if (slot_q == SLOT_W'(WINDOW_LEN - 1)) slot_q <= '0;
        else slot_q <= slot_q + SLOT_W'(1);
      end
      if (cmd_i.finish) lf_q <= mean_c;
    end
  end

  assign out_data_o = out_q;

endmodule
`default_nettype wire

// ----- hdl/rate_gated_height_smoother_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rate_gated_height_smoother_core: outlier-rejecting height smoother
// Rejects out-of-range and jumping ultrasonic readings, blends sharp steps
// and reports the rounded mean of a five-sample window in 1/16 mm.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: in_valid_i / in_stall_o with in_data_i carrying the high
//   and low bytes of one reading in mm. One transaction gives exactly one
//   result on out_valid_o / out_stall_i with out_data_o (filtered height,
//   raw reading, verdict).
//   A rejected reading loads its result in the check state, an accepted
//   reading after check, blend, window update, reciprocal multiply and
//   correction. The controller works on one reading at a time, so the
//   input is taken again in the cycle after the result is loaded. The
//   result sits in an output register, so a new reading is accepted
//   while an earlier result waits; if the receiver stalls, the next result
//   is held inside and in_stall_o stays high until the register frees.
//   Reset clears the window, the running total, the last filtered and last
//   accepted heights, and loads the register defaults. Registers are to be
//   written through the APB port only while no transaction is in flight;
//   the block itself does not enforce this.
// ----------------------------------------------------------------------------
module rate_gated_height_smoother_core import rghs_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  in_t               in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output out_t              out_data_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;

  // Configuration registers
  rghs_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Sequencer
  rghs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Filter datapath
  rghs_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_data_o (out_data_o)
  );

endmodule
`default_nettype wire
